### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define ASSERT_CHECK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion check failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion never-condition hit");
`else
`define ASSERT_CHECK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### hw/rtl/psfk_pkg.sv
package psfk_pkg;

    localparam int ANG_W = 16;
    localparam int LEN_W = 12;
    localparam int TRIG_W = 16;
    localparam int POS_W = 15;
    localparam int N_W = 22;
    localparam int V_W = 25;
    localparam int RECIP_W = 33;
    localparam int RECIP_SH = 32;
    localparam int T_W = 20;
    localparam int R_W = 21;
    localparam int XY_W = 34;
    localparam int PROD_W = 29;
    localparam int ACC_W = 35;

    localparam int CORDIC_STEPS = 17;
    localparam int SEG_LAT = 9 + CORDIC_STEPS;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [T_W-1:0] TWO_PI_U = 20'd411775;
    localparam logic signed [R_W-1:0] PI_Q16 = 21'sd205887;
    localparam logic signed [R_W-1:0] TWO_PI_Q16 = 21'sd411775;
    localparam logic signed [R_W-1:0] HALF_PI_Q16 = 21'sd102944;

    localparam logic signed [TRIG_W-1:0] TRIG_MAX = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] TRIG_MIN = -16'sd16384;
    localparam logic signed [ACC_W-1:0] POS_MAX = 35'sd16383;
    localparam logic signed [ACC_W-1:0] POS_MIN = -35'sd16384;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_END_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_LEN = 1'b1;
    localparam logic [LEN_W-1:0] END_LEN_RESET = 12'd1843;
    localparam logic [LEN_W-1:0] MID_LEN_RESET = 12'd614;

    // Operand handed from one segment cell to the next
    typedef struct packed {
        logic signed [ANG_W-1:0] a;
        logic signed [ANG_W-1:0] b;
        logic signed [N_W-1:0]   n;
        logic signed [ACC_W-1:0] sx;
        logic signed [ACC_W-1:0] sy;
    } psfk_carry_t;

    // Rotation state of one CORDIC step
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [R_W-1:0]  r;
        logic                   flip;
    } psfk_rot_t;

    // atan(2^-k) in units of 2^-16 rad
    function automatic logic signed [R_W-1:0] atan_q16(input int k);
        logic signed [R_W-1:0] v;
        case (k)
            0:  v = 21'sd51472;
            1:  v = 21'sd30386;
            2:  v = 21'sd16055;
            3:  v = 21'sd8150;
            4:  v = 21'sd4091;
            5:  v = 21'sd2047;
            6:  v = 21'sd1024;
            7:  v = 21'sd512;
            8:  v = 21'sd256;
            9:  v = 21'sd128;
            10: v = 21'sd64;
            11: v = 21'sd32;
            12: v = 21'sd16;
            13: v = 21'sd8;
            14: v = 21'sd4;
            15: v = 21'sd2;
            16: v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/psfk_cordic_stage.sv
module psfk_cordic_stage
    import psfk_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic      clk,
    input  psfk_rot_t rot_in,
    output psfk_rot_t rot_out
);

    localparam logic signed [R_W-1:0] ATAN = atan_q16(K);

    psfk_rot_t rot_next;
    psfk_rot_t rot_reg;

    // one micro-rotation, shifts floor
    always_comb
    begin
        rot_next.flip = rot_in.flip;
        if (rot_in.r >= 0)
        begin
            rot_next.x = rot_in.x - (rot_in.y >>> K);
            rot_next.y = rot_in.y + (rot_in.x >>> K);
            rot_next.r = rot_in.r - ATAN;
        end
        else
        begin
            rot_next.x = rot_in.x + (rot_in.y >>> K);
            rot_next.y = rot_in.y - (rot_in.x >>> K);
            rot_next.r = rot_in.r + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    assign rot_out = rot_reg;

endmodule

### hw/rtl/psfk_segment.sv
module psfk_segment
    import psfk_pkg::*;
#(
    parameter bit USE_B    = 1'b0,
    parameter int HALF_SEG = 6
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  psfk_carry_t               carry_in,
    input  logic [LEN_W-1:0]          len,
    output logic                      valid_out,
    output psfk_carry_t               carry_out,
    output logic signed [TRIG_W-1:0]  cos_out,
    output logic signed [TRIG_W-1:0]  sin_out
);

    // ceil(2^32 / HALF_SEG): exact quotient for every dividend below 2^25
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(HALF_SEG) - 64'd1) / 64'(HALF_SEG));
    localparam logic [V_W-1:0] HALF_ROUND = V_W'(HALF_SEG / 2);

    logic                        valid_reg [0:SEG_LAT-1];
    psfk_carry_t                 pl_reg [0:SEG_LAT-1];

    logic signed [N_W-1:0]       n_next;
    logic signed [N_W-1:0]       n_abs;
    logic                        neg2_reg;
    logic [V_W-1:0]              v2_reg;
    logic                        neg3_reg;
    logic [RECIP_W+V_W-1:0]      p3_reg;
    logic [T_W-1:0]              t_mag;
    logic [T_W-1:0]              t_red;
    logic signed [R_W-1:0]       r4_reg;
    logic signed [R_W-1:0]       r5_next;
    logic signed [R_W-1:0]       r5_reg;
    psfk_rot_t                   rot6_next;
    psfk_rot_t                   rot6_reg;
    psfk_rot_t                   rot [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]      xf;
    logic signed [XY_W-1:0]      yf;
    logic signed [XY_W-1:0]      xr;
    logic signed [XY_W-1:0]      yr;
    logic signed [TRIG_W-1:0]    c_next;
    logic signed [TRIG_W-1:0]    s_next;
    logic signed [TRIG_W-1:0]    c24_reg;
    logic signed [TRIG_W-1:0]    s24_reg;
    logic signed [PROD_W-1:0]    pc25_reg;
    logic signed [PROD_W-1:0]    ps25_reg;
    logic signed [TRIG_W-1:0]    c25_reg;
    logic signed [TRIG_W-1:0]    s25_reg;
    logic signed [ACC_W-1:0]     sx26_reg;
    logic signed [ACC_W-1:0]     sy26_reg;
    logic signed [TRIG_W-1:0]    c26_reg;
    logic signed [TRIG_W-1:0]    s26_reg;

    // cumulative bend numerator
    assign n_next = carry_in.n + (USE_B ? N_W'(carry_in.b) : N_W'(carry_in.a));
    assign n_abs  = pl_reg[0].n[N_W-1] ? -pl_reg[0].n : pl_reg[0].n;

    // quotient and one-step reduction by 2*pi
    assign t_mag = p3_reg[RECIP_SH +: T_W];
    assign t_red = (t_mag >= TWO_PI_U) ? t_mag - TWO_PI_U : t_mag;

    // wrap into [-pi, pi]
    always_comb
    begin
        if (r4_reg > PI_Q16)
            r5_next = r4_reg - TWO_PI_Q16;
        else if (r4_reg < -PI_Q16)
            r5_next = r4_reg + TWO_PI_Q16;
        else
            r5_next = r4_reg;
    end

    // fold into [-pi/2, pi/2], flip sign of result later
    always_comb
    begin
        rot6_next.x    = CORDIC_GAIN;
        rot6_next.y    = '0;
        rot6_next.flip = 1'b0;
        rot6_next.r    = r5_reg;
        if (r5_reg > HALF_PI_Q16)
        begin
            rot6_next.r    = r5_reg - PI_Q16;
            rot6_next.flip = 1'b1;
        end
        else if (r5_reg < -HALF_PI_Q16)
        begin
            rot6_next.r    = r5_reg + PI_Q16;
            rot6_next.flip = 1'b1;
        end
    end

    // CORDIC rotation row
    assign rot[0] = rot6_reg;
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        psfk_cordic_stage #(.K(k)) u_stage
        (
            .clk     (clk),
            .rot_in  (rot[k]),
            .rot_out (rot[k+1])
        );
    end

    // sign restore, round to Q1.14 and clamp
    assign xf = rot[CORDIC_STEPS].flip ? -rot[CORDIC_STEPS].x : rot[CORDIC_STEPS].x;
    assign yf = rot[CORDIC_STEPS].flip ? -rot[CORDIC_STEPS].y : rot[CORDIC_STEPS].y;
    assign xr = (xf + XY_W'(32768)) >>> 16;
    assign yr = (yf + XY_W'(32768)) >>> 16;

    always_comb
    begin
        if (xr > XY_W'(TRIG_MAX))
            c_next = TRIG_MAX;
        else if (xr < XY_W'(TRIG_MIN))
            c_next = TRIG_MIN;
        else
            c_next = xr[TRIG_W-1:0];
        if (yr > XY_W'(TRIG_MAX))
            s_next = TRIG_MAX;
        else if (yr < XY_W'(TRIG_MIN))
            s_next = TRIG_MIN;
        else
            s_next = yr[TRIG_W-1:0];
    end

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEG_LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= valid_in;
            for (int i = 1; i < SEG_LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        pl_reg[0].a  <= carry_in.a;
        pl_reg[0].b  <= carry_in.b;
        pl_reg[0].n  <= n_next;
        pl_reg[0].sx <= carry_in.sx;
        pl_reg[0].sy <= carry_in.sy;
        for (int i = 1; i < SEG_LAT; i++)
            pl_reg[i] <= pl_reg[i-1];

        neg2_reg <= pl_reg[0].n[N_W-1];
        v2_reg   <= V_W'({n_abs[20:0], 3'b000}) + HALF_ROUND;
        neg3_reg <= neg2_reg;
        p3_reg   <= {{RECIP_W{1'b0}}, v2_reg} * {{V_W{1'b0}}, RECIP};
        r4_reg   <= neg3_reg ? -$signed({1'b0, t_red}) : $signed({1'b0, t_red});
        r5_reg   <= r5_next;
        rot6_reg <= rot6_next;

        c24_reg  <= c_next;
        s24_reg  <= s_next;

        pc25_reg <= $signed({1'b0, len}) * c24_reg;
        ps25_reg <= $signed({1'b0, len}) * s24_reg;
        c25_reg  <= c24_reg;
        s25_reg  <= s24_reg;

        sx26_reg <= pl_reg[SEG_LAT-2].sx + ACC_W'(pc25_reg);
        sy26_reg <= pl_reg[SEG_LAT-2].sy + ACC_W'(ps25_reg);
        c26_reg  <= c25_reg;
        s26_reg  <= s25_reg;
    end

    assign valid_out    = valid_reg[SEG_LAT-1];
    assign carry_out.a  = pl_reg[SEG_LAT-1].a;
    assign carry_out.b  = pl_reg[SEG_LAT-1].b;
    assign carry_out.n  = pl_reg[SEG_LAT-1].n;
    assign carry_out.sx = sx26_reg;
    assign carry_out.sy = sy26_reg;
    assign cos_out      = c26_reg;
    assign sin_out      = s26_reg;

endmodule

### hw/rtl/planar_snake_forward_kinematics.sv
// Planar snake forward kinematics: tip pose of a chain of SEGMENTS segments.
// Input: bend_angle_a/bend_angle_b are taken on a rising edge with start high
// and busy low. busy stays low: a new pair can be taken in every cycle.
// Output: done is high for one cycle with tip_x, tip_y, tip_cos, tip_sin;
// the receiver takes the transfer in that cycle and cannot stall it.
// Each segment cell is a 26-stage pipeline (bend accumulation, angle scaling,
// 2*pi reduction, wrap and fold, 17-step CORDIC, length multiply,
// accumulate), the cells are chained one per segment, and the done strobe
// and the tip outputs are registered after the last cell.
// Throughput: one item per cycle, set by the fully pipelined cell chain.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0: end segment length, 1: middle segment length) at once; write only while
// no item is in flight.
// Reset: rst_n clears all valid flags and loads the default lengths; items
// in flight are dropped and no done follows for them.
`include "assert_macros.svh"

module planar_snake_forward_kinematics
    import psfk_pkg::*;
#(
    parameter int SEGMENTS = 13
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ANG_W-1:0]  bend_angle_a,
    input  logic signed [ANG_W-1:0]  bend_angle_b,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [LEN_W-1:0]         cfg_data,
    output logic                     done,
    output logic signed [POS_W-1:0]  tip_x,
    output logic signed [POS_W-1:0]  tip_y,
    output logic signed [TRIG_W-1:0] tip_cos,
    output logic signed [TRIG_W-1:0] tip_sin
);

    localparam int HALF_SEG = (SEGMENTS / 2 > 0) ? SEGMENTS / 2 : 1;

    logic [LEN_W-1:0]          end_len_reg;
    logic [LEN_W-1:0]          mid_len_reg;

    logic                      chain_valid [0:SEGMENTS];
    psfk_carry_t               chain [0:SEGMENTS];
    logic signed [TRIG_W-1:0]  seg_cos [0:SEGMENTS-1];
    logic signed [TRIG_W-1:0]  seg_sin [0:SEGMENTS-1];

    logic signed [ACC_W-1:0]   xr;
    logic signed [ACC_W-1:0]   yr;
    logic signed [POS_W-1:0]   x_next;
    logic signed [POS_W-1:0]   y_next;

    logic                      done_reg;
    logic signed [POS_W-1:0]   tip_x_reg;
    logic signed [POS_W-1:0]   tip_y_reg;
    logic signed [TRIG_W-1:0]  tip_cos_reg;
    logic signed [TRIG_W-1:0]  tip_sin_reg;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_len_reg <= END_LEN_RESET;
            mid_len_reg <= MID_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_END_LEN: end_len_reg <= cfg_data;
                REG_MID_LEN: mid_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // head of the chain
    assign chain_valid[0] = start & ~busy;
    assign chain[0].a     = bend_angle_a;
    assign chain[0].b     = bend_angle_b;
    assign chain[0].n     = '0;
    assign chain[0].sx    = '0;
    assign chain[0].sy    = '0;

    // one cell per segment; even segments bend by a, odd by b
    for (genvar i = 0; i < SEGMENTS; i++)
    begin : g_seg
        psfk_segment #(
            .USE_B    (i % 2 == 1),
            .HALF_SEG (HALF_SEG)
        ) u_seg
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[i]),
            .carry_in  (chain[i]),
            .len       ((i == 0 || i == SEGMENTS - 1) ? end_len_reg : mid_len_reg),
            .valid_out (chain_valid[i+1]),
            .carry_out (chain[i+1]),
            .cos_out   (seg_cos[i]),
            .sin_out   (seg_sin[i])
        );
    end

    // round Q.14 sums and saturate
    assign xr = (chain[SEGMENTS].sx + ACC_W'(8192)) >>> 14;
    assign yr = (chain[SEGMENTS].sy + ACC_W'(8192)) >>> 14;

    always_comb
    begin
        if (xr > POS_MAX)
            x_next = POS_MAX[POS_W-1:0];
        else if (xr < POS_MIN)
            x_next = POS_MIN[POS_W-1:0];
        else
            x_next = xr[POS_W-1:0];
        if (yr > POS_MAX)
            y_next = POS_MAX[POS_W-1:0];
        else if (yr < POS_MIN)
            y_next = POS_MIN[POS_W-1:0];
        else
            y_next = yr[POS_W-1:0];
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain_valid[SEGMENTS];
    end

    // result payload
    always_ff @(posedge clk)
    begin
        tip_x_reg   <= x_next;
        tip_y_reg   <= y_next;
        tip_cos_reg <= seg_cos[SEGMENTS-1];
        tip_sin_reg <= seg_sin[SEGMENTS-1];
    end

    assign done    = done_reg;
    assign tip_x   = tip_x_reg;
    assign tip_y   = tip_y_reg;
    assign tip_cos = tip_cos_reg;
    assign tip_sin = tip_sin_reg;

    `ASSERT_CHECK(a_done_follows, clk, rst_n, chain_valid[SEGMENTS] |=> done_reg)
    `ASSERT_CHECK(a_no_stray_done, clk, rst_n, !chain_valid[SEGMENTS] |=> !done_reg)
    `ASSERT_NEVER(a_cos_range, clk, rst_n, done_reg && (tip_cos_reg > TRIG_MAX || tip_cos_reg < TRIG_MIN))
    `ASSERT_NEVER(a_sin_range, clk, rst_n, done_reg && (tip_sin_reg > TRIG_MAX || tip_sin_reg < TRIG_MIN))

endmodule
